### rtl/brb_pkg.sv
package brb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_READ
    } brb_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic out_fire;
        logic streaming;
    } brb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_read;
        logic block_end;
        logic read_stream;
        logic last_byte;
    } brb_stat_t;

endpackage

### rtl/brb_in_if.sv
interface brb_in_if
    import brb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data_in;
    logic              block_end;

    modport source (output valid, output op, output length, output data_in,
                    output block_end, input ready);
    modport sink   (input valid, input op, input length, input data_in,
                    input block_end, output ready);
endinterface

### rtl/brb_out_if.sv
interface brb_out_if
    import brb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic                data_valid;
    logic [STATUS_W-1:0] status;
    logic                run_last;
    logic [LEN_W-1:0]    fill_count;

    modport source (output valid, output data_out, output data_valid, output status,
                    output run_last, output fill_count, input ready);
    modport sink   (input valid, input data_out, input data_valid, input status,
                    input run_last, input fill_count, output ready);
endinterface

### rtl/brb_ctrl.sv
module brb_ctrl
    import brb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    input  brb_stat_t stat,
    output logic      in_ready,
    output logic      out_valid,
    output brb_cmd_t  cmd
);

    brb_state_t state_reg;
    brb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        // a pending single result can be taken in the same cycle a new request enters
        in_ready      = (state_reg == S_IDLE) || ((state_reg == S_RESP) && out_ready);
        out_valid     = (state_reg != S_IDLE);
        cmd.accept    = in_valid && in_ready;
        cmd.out_fire  = out_valid && out_ready;
        cmd.streaming = (state_reg == S_READ);
        state_next    = state_reg;

        case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (cmd.accept)
                begin
                    if (stat.op_read)
                    begin
                        state_next = stat.read_stream ? S_READ : S_RESP;
                    end
                    else
                    begin
                        state_next = stat.block_end ? S_RESP : S_IDLE;
                    end
                end
                else if ((state_reg == S_RESP) && cmd.out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (cmd.out_fire && stat.last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/brb_dp.sv
module brb_dp
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                op,
    input  logic [LEN_W-1:0]    length,
    input  logic [DATA_W-1:0]   data_in,
    input  logic                block_end,
    input  brb_cmd_t            cmd,
    output brb_stat_t           stat,
    output logic [DATA_W-1:0]   data_out,
    output logic                data_valid,
    output logic [STATUS_W-1:0] status,
    output logic                run_last,
    output logic [LEN_W-1:0]    fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CAP_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [LEN_W-1:0]    capacity_reg;
    logic [IDX_W-1:0]    read_index_reg;
    logic [IDX_W-1:0]    write_index_reg;
    logic                full_reg;
    logic                wip_reg;
    logic                acc_reg;
    logic [LEN_W-1:0]    blen_reg;
    logic [CAP_W-1:0]    brx_reg;
    logic [IDX_W-1:0]    wptr_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [CAP_W-1:0]    res_fill_reg;
    logic                res_dv_reg;

    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] fill;
    logic [CAP_W-1:0] free_space;
    logic             acc_eff;
    logic [LEN_W-1:0] blen_eff;
    logic [CAP_W-1:0] brx_eff;
    logic [IDX_W-1:0] wptr_eff;
    logic             do_store;
    logic [CAP_W-1:0] brx_after;
    logic [CAP_W-1:0] wp1;
    logic [IDX_W-1:0] wptr_after;
    logic [CAP_W:0]   fill_sum;
    logic [CAP_W-1:0] fill_after;
    logic [CAP_W-1:0] rp1;
    logic [IDX_W-1:0] r_inc;
    logic [IDX_W-1:0] raddr;
    logic             rd_short;
    logic             rd_stream;
    logic             advance;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (capacity_reg > LEN_W'(DEPTH))
        begin
            cap = CAP_W'(DEPTH);
        end
        else
        begin
            cap = capacity_reg[CAP_W-1:0];
        end

        if (full_reg)
        begin
            fill = cap;
        end
        else if (write_index_reg >= read_index_reg)
        begin
            fill = CAP_W'(write_index_reg) - CAP_W'(read_index_reg);
        end
        else
        begin
            fill = cap - CAP_W'(read_index_reg) + CAP_W'(write_index_reg);
        end
        free_space = cap - fill;

        // first byte of a block latches length and the space check
        acc_eff  = wip_reg ? acc_reg : (LEN_W'(free_space) >= length);
        blen_eff = wip_reg ? blen_reg : length;
        brx_eff  = wip_reg ? brx_reg : '0;
        wptr_eff = wip_reg ? wptr_reg : write_index_reg;
        do_store = acc_eff && (LEN_W'(brx_eff) < blen_eff);
        brx_after = brx_eff + CAP_W'(do_store);

        wp1 = CAP_W'(wptr_eff) + CAP_W'(1);
        if (!do_store)
        begin
            wptr_after = wptr_eff;
        end
        else if (wp1 == cap)
        begin
            wptr_after = '0;
        end
        else
        begin
            wptr_after = wp1[IDX_W-1:0];
        end

        fill_sum   = {1'b0, fill} + {1'b0, brx_after};
        fill_after = acc_eff ? fill_sum[CAP_W-1:0] : fill;

        rp1   = CAP_W'(read_index_reg) + CAP_W'(1);
        r_inc = (rp1 == cap) ? '0 : rp1[IDX_W-1:0];

        rd_short  = LEN_W'(fill) < length;
        rd_stream = (length != '0) && !rd_short;

        advance = cmd.streaming && cmd.out_fire;
        raddr   = advance ? r_inc : read_index_reg;
    end

    // byte store; the read port keeps rdata_reg on the byte at the read index
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (op == OP_WRITE) && do_store)
        begin
            mem[wptr_eff] <= data_in;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= LEN_W'(DEPTH);
            read_index_reg  <= '0;
            write_index_reg <= '0;
            full_reg        <= 1'b0;
            wip_reg         <= 1'b0;
            acc_reg         <= 1'b0;
            blen_reg        <= '0;
            brx_reg         <= '0;
            wptr_reg        <= '0;
            rem_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg    <= cfg_wr_data;
            read_index_reg  <= '0;
            write_index_reg <= '0;
            full_reg        <= 1'b0;
            wip_reg         <= 1'b0;
            acc_reg         <= 1'b0;
            blen_reg        <= '0;
            brx_reg         <= '0;
        end
        else if (cmd.accept)
        begin
            if (op == OP_WRITE)
            begin
                if (block_end)
                begin
                    wip_reg  <= 1'b0;
                    acc_reg  <= 1'b0;
                    blen_reg <= '0;
                    brx_reg  <= '0;
                    if (acc_eff && (brx_after != '0))
                    begin
                        write_index_reg <= wptr_after;
                        full_reg        <= (fill_after == cap);
                    end
                end
                else
                begin
                    wip_reg  <= 1'b1;
                    acc_reg  <= acc_eff;
                    blen_reg <= blen_eff;
                    brx_reg  <= brx_after;
                    wptr_reg <= wptr_after;
                end
            end
            else
            begin
                rem_reg <= length;
                if (rd_stream)
                begin
                    full_reg <= 1'b0;
                end
            end
        end
        else if (advance)
        begin
            read_index_reg <= r_inc;
            rem_reg        <= rem_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (op == OP_WRITE)
            begin
                res_dv_reg     <= 1'b0;
                res_status_reg <= acc_eff ? STATUS_OK : STATUS_NO_SPACE;
                res_fill_reg   <= fill_after;
            end
            else
            begin
                res_dv_reg     <= rd_stream;
                res_status_reg <= ((length != '0) && rd_short) ? STATUS_NO_DATA : STATUS_OK;
                res_fill_reg   <= rd_stream ? (fill - length[CAP_W-1:0]) : fill;
            end
        end
    end

    assign stat.op_read     = (op == OP_READ);
    assign stat.block_end   = block_end;
    assign stat.read_stream = rd_stream;
    assign stat.last_byte   = (rem_reg == LEN_W'(1));

    assign data_out   = res_dv_reg ? rdata_reg : '0;
    assign data_valid = res_dv_reg;
    assign status     = res_status_reg;
    assign run_last   = res_dv_reg ? (rem_reg == LEN_W'(1)) : 1'b1;
    assign fill_count = LEN_W'(res_fill_reg);

endmodule

### rtl/byte_ring_buffer_block_rw_top.sv
// Write block bytes: one request per cycle; a non-final byte gives no result.
// Final byte of a block or a failed/zero-length read: one result, valid the next cycle;
// the next request can enter in the cycle that result is taken.
// Read of N bytes: first byte the cycle after the request, then one byte per cycle
// from the registered read port of the byte store; no request is taken until it ends.
// Reset (rst_n low, async): buffer empty, capacity DEPTH, no block in progress.
module byte_ring_buffer_block_rw_top
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    brb_in_if.sink           req,
    brb_out_if.source        rsp
);

    brb_cmd_t  cmd;
    brb_stat_t stat;

    brb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    brb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (req.op),
        .length      (req.length),
        .data_in     (req.data_in),
        .block_end   (req.block_end),
        .cmd         (cmd),
        .stat        (stat),
        .data_out    (rsp.data_out),
        .data_valid  (rsp.data_valid),
        .status      (rsp.status),
        .run_last    (rsp.run_last),
        .fill_count  (rsp.fill_count)
    );

endmodule

### rtl/brb_checker.sv
module brb_checker
    import brb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [DATA_W-1:0]   data_out,
    input logic                data_valid,
    input logic [STATUS_W-1:0] status,
    input logic                run_last,
    input logic [LEN_W-1:0]    fill_count
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_out)
            && $stable(data_valid) && $stable(status) && $stable(run_last)
            && $stable(fill_count)))
        else $error("result changed while stalled");

    // a read run continues with the same fill count
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && data_valid && !run_last) |=>
            (out_valid && data_valid && (status == STATUS_OK)
             && (fill_count == $past(fill_count))))
        else $error("read run broken");

    // no request taken while read bytes are being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |-> !in_ready)
        else $error("request taken during read run");

endmodule

bind byte_ring_buffer_block_rw_top brb_checker u_brb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .data_out   (rsp.data_out),
    .data_valid (rsp.data_valid),
    .status     (rsp.status),
    .run_last   (rsp.run_last),
    .fill_count (rsp.fill_count)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brb_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic                data_valid;
        logic [STATUS_W-1:0] status;
        logic                run_last;
        logic [LEN_W-1:0]    fill;
    } ring_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    brb_in_if  req_ch ();
    brb_out_if rsp_ch ();

    byte_ring_buffer_block_rw_top #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // predictor state
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int                rd_ptr;
    int                wr_ptr;
    bit                ring_full;
    bit                blk_open;
    bit                blk_ok;
    int                blk_len;
    int                blk_cnt;
    int                cap_cfg;

    ring_result_t ring_expected [$];

    int cycles;
    int mismatches;
    int requests_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int ring_cap();
        if (cap_cfg < 1)
        begin
            return 1;
        end
        if (cap_cfg > RING_DEPTH)
        begin
            return RING_DEPTH;
        end
        return cap_cfg;
    endfunction

    function automatic int ring_fill();
        int c;
        c = ring_cap();
        if (ring_full)
        begin
            return c;
        end
        if (wr_ptr >= rd_ptr)
        begin
            return wr_ptr - rd_ptr;
        end
        return (c - rd_ptr) + wr_ptr;
    endfunction

    function automatic void ring_configure(input int value);
        cap_cfg   = value;
        rd_ptr    = 0;
        wr_ptr    = 0;
        ring_full = 1'b0;
        blk_open  = 1'b0;
        blk_ok    = 1'b0;
        blk_len   = 0;
        blk_cnt   = 0;
    endfunction

    // Works out the results of one accepted request and queues them.
    function automatic void ring_step(input logic op, input int len,
                                      input logic [DATA_W-1:0] data, input logic last_byte);
        int           c;
        int           fill_then;
        int           i;
        ring_result_t r;
        ring_result_t step_out [$];
        c = ring_cap();
        r = '0;
        if (op == OP_WRITE)
        begin
            if (!blk_open)
            begin
                blk_open = 1'b1;
                blk_len  = len;
                blk_cnt  = 0;
                blk_ok   = (c - ring_fill()) >= len;
            end
            if (blk_ok && blk_cnt < blk_len)
            begin
                ring_mem[(wr_ptr + blk_cnt) % c] = data;
                blk_cnt++;
            end
            if (last_byte)
            begin
                r.status = STATUS_NO_SPACE;
                if (blk_ok)
                begin
                    fill_then = ring_fill();
                    r.status  = STATUS_OK;
                    if (blk_cnt != 0)
                    begin
                        wr_ptr    = (wr_ptr + blk_cnt) % c;
                        ring_full = (fill_then + blk_cnt) >= c;
                    end
                end
                blk_open   = 1'b0;
                blk_ok     = 1'b0;
                blk_len    = 0;
                blk_cnt    = 0;
                r.run_last = 1'b1;
                step_out.push_back(r);
            end
        end
        else if (len == 0)
        begin
            r.status   = STATUS_OK;
            r.run_last = 1'b1;
            step_out.push_back(r);
        end
        else if (ring_fill() < len)
        begin
            r.status   = STATUS_NO_DATA;
            r.run_last = 1'b1;
            step_out.push_back(r);
        end
        else
        begin
            for (i = 0; i < len; i++)
            begin
                r.data       = ring_mem[(rd_ptr + i) % c];
                r.data_valid = 1'b1;
                r.status     = STATUS_OK;
                r.run_last   = (i == len - 1);
                step_out.push_back(r);
            end
            rd_ptr    = (rd_ptr + len) % c;
            ring_full = 1'b0;
        end
        // fill count reflects the state after the whole request
        fill_then = ring_fill();
        foreach (step_out[k])
        begin
            step_out[k].fill = LEN_W'(fill_then);
            ring_expected.push_back(step_out[k]);
        end
    endfunction

    function automatic void flag_mismatch(input string what, input ring_result_t want,
                                          input ring_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected data=%0d dv=%0d st=%0d last=%0d fill=%0d,",
                     $realtime, what, want.data, want.data_valid, want.status,
                     want.run_last, want.fill);
            $display("    got data=%0d dv=%0d st=%0d last=%0d fill=%0d",
                     got.data, got.data_valid, got.status, got.run_last, got.fill);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        ring_result_t got;
        ring_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.data       = rsp_ch.data_out;
            got.data_valid = rsp_ch.data_valid;
            got.status     = rsp_ch.status;
            got.run_last   = rsp_ch.run_last;
            got.fill       = rsp_ch.fill_count;
            if (ring_expected.size() == 0)
            begin
                flag_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = ring_expected.pop_front();
                if (got !== want)
                begin
                    flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back requests need no gap.
    task automatic send_request(input logic op, input int len, input int data,
                                input logic last_byte);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.length    <= LEN_W'(len);
        req_ch.data_in   <= DATA_W'(data);
        req_ch.block_end <= last_byte;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        ring_step(op, len, DATA_W'(data), last_byte);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        wait (ring_expected.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        settle();
        // a non-final byte gives no result, so give the block time to finish it
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LEN_W'(value);
        ring_configure(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mid_read >= 0 puts a read request right after the first byte of a block of two or more bytes
    task automatic write_block(input int len, input int n_bytes, input int mid_read);
        int i;
        if (n_bytes < 1)
        begin
            n_bytes = 1;
        end
        for (i = 0; i < n_bytes; i++)
        begin
            send_request(OP_WRITE, len, $urandom_range(255), i == n_bytes - 1);
            if (i == 0 && mid_read >= 0 && n_bytes > 1)
            begin
                send_request(OP_READ, mid_read, $urandom_range(255), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_empty_and_zero();
        send_request(OP_READ, 0, 0, 1'b0);
        send_request(OP_READ, 64, 255, 1'b1);
        send_request(OP_WRITE, 0, 255, 1'b1);
        send_request(OP_READ, 63, 0, 1'b0);
    endtask

    task automatic test_block_roundtrip();
        send_request(OP_WRITE, 2, 8'h00, 1'b0);
        send_request(OP_WRITE, 2, 8'hFF, 1'b1);
        send_request(OP_READ, 2, 8'h00, 1'b0);
    endtask

    task automatic test_short_and_long_blocks();
        // ends early: only the one byte is kept
        send_request(OP_WRITE, 3, 8'h5A, 1'b1);
        // runs long: bytes past the length are dropped
        send_request(OP_WRITE, 1, 8'hA5, 1'b0);
        send_request(OP_WRITE, 1, 8'h3C, 1'b0);
        send_request(OP_WRITE, 1, 8'hC3, 1'b1);
        send_request(OP_READ, 2, 8'h00, 1'b0);
    endtask

    task automatic test_small_capacity();
        write_capacity(4);
        send_request(OP_WRITE, 64, 8'h01, 1'b0);
        send_request(OP_WRITE, 64, 8'h02, 1'b1);
        write_block(4, 4, -1);
        send_request(OP_WRITE, 1, 8'h07, 1'b1);
        send_request(OP_READ, 5, 8'h00, 1'b0);
        send_request(OP_READ, 4, 8'h00, 1'b0);
        write_capacity(1);
        write_block(1, 1, -1);
        send_request(OP_READ, 1, 8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        int i;
        write_capacity(64);
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 250;
        for (i = 0; i < 6; i++)
        begin
            write_block(8, 8, -1);
            send_request(OP_READ, 8, 0, 1'b0);
        end
        settle();
    endtask

    task automatic random_sequence();
        int c;
        int fill;
        int free_b;
        int kind;
        int len;
        int n;
        c      = ring_cap();
        fill   = ring_fill();
        free_b = c - fill;
        kind   = $urandom_range(99);
        if (kind < 45)
        begin
            len = ($urandom_range(3) == 0) ? $urandom_range(c, 0) : $urandom_range(free_b, 0);
            write_block(len, len, ($urandom_range(9) == 0) ? $urandom_range(fill, 0) : -1);
        end
        else if (kind < 80)
        begin
            len = ($urandom_range(4) == 0) ? $urandom_range(64, 0) : $urandom_range(fill, 0);
            send_request(OP_READ, len, $urandom_range(255), 1'($urandom_range(1)));
        end
        else if (kind < 90)
        begin
            len = $urandom_range(c, 1);
            write_block(len, $urandom_range(len, 1), -1);
        end
        else if (kind < 96)
        begin
            len = $urandom_range(free_b, 0);
            write_block(len, len + $urandom_range(3, 1), -1);
        end
        else
        begin
            // unfinished block: later writes continue it
            for (n = $urandom_range(3, 1); n > 0; n--)
            begin
                send_request(OP_WRITE, $urandom_range(64, 0), $urandom_range(255), 1'b0);
            end
        end
    endtask

    task automatic test_random(input int n_requests, input int tx_pct, input int rx_pct);
        int start;
        int seg_end;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = requests_sent;
        while (requests_sent - start < n_requests)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                write_capacity(1);
            end
            else if (pick < 3)
            begin
                write_capacity(64);
            end
            else
            begin
                write_capacity($urandom_range(63, 2));
            end
            seg_end = requests_sent + 25;
            while (requests_sent < seg_end && requests_sent - start < n_requests)
            begin
                random_sequence();
            end
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_WRITE;
        req_ch.length    = '0;
        req_ch.data_in   = '0;
        req_ch.block_end = 1'b0;
        rsp_ch.ready     = 1'b0;
        cycles           = 0;
        mismatches       = 0;
        requests_sent    = 0;
        rx_hold_cycles   = 0;
        tx_idle_pct      = 8;
        rx_idle_pct      = 55;
        ring_configure(RING_DEPTH);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_and_zero();
        test_block_roundtrip();
        test_short_and_long_blocks();
        test_small_capacity();
        test_random(50, 8, 55);
        test_random(50, 55, 8);
        test_random(40, 0, 0);
        test_backpressure();

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && ring_expected.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/brb_pkg.sv
rtl/brb_in_if.sv
rtl/brb_out_if.sv
rtl/brb_ctrl.sv
rtl/brb_dp.sv
rtl/byte_ring_buffer_block_rw_top.sv
rtl/brb_checker.sv
bench/testbench.sv
